// ===== rtl/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

    localparam int DATA_WIDTH = 16;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_M00   = 2'd1;
    localparam logic [1:0] BR_M11   = 2'd2;
    localparam logic [1:0] BR_M22   = 2'd3;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] m00;
        logic signed [DATA_WIDTH-1:0] m01;
        logic signed [DATA_WIDTH-1:0] m02;
        logic signed [DATA_WIDTH-1:0] m10;
        logic signed [DATA_WIDTH-1:0] m11;
        logic signed [DATA_WIDTH-1:0] m12;
        logic signed [DATA_WIDTH-1:0] m20;
        logic signed [DATA_WIDTH-1:0] m21;
        logic signed [DATA_WIDTH-1:0] m22;
    } t_mat_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quat_w;
        logic signed [DATA_WIDTH-1:0] quat_x;
        logic signed [DATA_WIDTH-1:0] quat_y;
        logic signed [DATA_WIDTH-1:0] quat_z;
        logic [1:0]                   branch_taken;
        logic                         degenerate;
    } t_quat_out;

    // Side data carried along the root and divider chains.
    typedef struct packed {
        logic [1:0] branch;
        logic       degen;
    } t_ctl;

endpackage
`default_nettype wire

// ===== rtl/rmq_front.sv =====
// Entry stage: branch selection, radicand and off-diagonal numerators.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_front #(
    parameter int FRAC_BITS = 14,
    parameter int RW        = 20,
    parameter int XW        = 36
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_en,
    input  wire                                 i_valid,
    input  wire  rmq_pkg::t_mat_in              i_mat,
    output logic                                o_valid,
    output rmq_pkg::t_ctl                       o_ctl,
    output logic [XW-1:0]                       o_x,
    output logic [2:0][rmq_pkg::DATA_WIDTH:0]   o_num
);
    localparam int NB = rmq_pkg::DATA_WIDTH + 1;
    localparam logic signed [RW-1:0] ONE = RW'(1) <<< FRAC_BITS;

    logic signed [RW-1:0] a00, a11, a22, trace, rad;
    logic signed [NB-1:0] b01, b02, b10, b12, b20, b21;
    logic signed [NB-1:0] n0, n1, n2;
    logic [1:0]           br;
    logic                 r_valid;
    rmq_pkg::t_ctl        r_ctl;
    logic [XW-1:0]        r_x;
    logic [2:0][NB-1:0]   r_num;

    always_comb begin
        a00 = RW'(i_mat.m00);
        a11 = RW'(i_mat.m11);
        a22 = RW'(i_mat.m22);
        b01 = NB'(i_mat.m01);
        b02 = NB'(i_mat.m02);
        b10 = NB'(i_mat.m10);
        b12 = NB'(i_mat.m12);
        b20 = NB'(i_mat.m20);
        b21 = NB'(i_mat.m21);
        trace = a00 + a11 + a22;
        if (trace > 0) begin
            br = rmq_pkg::BR_TRACE;
            rad = trace + ONE;
            n0 = b21 - b12; n1 = b02 - b20; n2 = b10 - b01;
        end else if (a00 > a11 && a00 > a22) begin
            br = rmq_pkg::BR_M00;
            rad = ONE + a00 - a11 - a22;
            n0 = b21 - b12; n1 = b01 + b10; n2 = b02 + b20;
        end else if (a11 > a22) begin
            br = rmq_pkg::BR_M11;
            rad = ONE + a11 - a00 - a22;
            n0 = b02 - b20; n1 = b01 + b10; n2 = b12 + b21;
        end else begin
            br = rmq_pkg::BR_M22;
            rad = ONE + a22 - a00 - a11;
            n0 = b10 - b01; n1 = b02 + b20; n2 = b12 + b21;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.branch <= br;
            r_ctl.degen  <= (rad <= 0);
            r_x          <= (rad <= 0) ? '0 : (XW'(rad[RW-2:0]) << (FRAC_BITS + 2));
            r_num        <= {n2, n1, n0};
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_x     = r_x;
    assign o_num   = r_num;
endmodule
`default_nettype wire

// ===== rtl/rmq_sqrt_cell.sv =====
// One cell of the square root chain: settles one root bit per cell.
// Depends on rmq_pkg for the side data type.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_cell #(
    parameter int NP = 18,
    parameter int NB = 17
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire  rmq_pkg::t_ctl     i_ctl,
    input  wire  [2:0][NB-1:0]      i_num,
    input  wire  [2*NP-1:0]         i_x,
    input  wire  [NP+1:0]           i_rem,
    input  wire  [NP-1:0]           i_root,
    output logic                    o_valid,
    output rmq_pkg::t_ctl           o_ctl,
    output logic [2:0][NB-1:0]      o_num,
    output logic [2*NP-1:0]         o_x,
    output logic [NP+1:0]           o_rem,
    output logic [NP-1:0]           o_root
);
    logic [NP+1:0] rem_t, trial;
    logic          fits;

    always_comb begin
        rem_t = {i_rem[NP-1:0], i_x[2*NP-1 -: 2]};
        trial = {i_root, 2'b01};
        fits  = rem_t >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl  <= i_ctl;
            o_num  <= i_num;
            o_x    <= i_x << 2;
            o_rem  <= fits ? rem_t - trial : rem_t;
            o_root <= {i_root[NP-2:0], fits};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rmq_div_cell.sv =====
// One cell of the divider chain: one quotient bit for each of three dividers.
// Depends on rmq_pkg for the side data type.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_cell #(
    parameter int NP  = 18,
    parameter int NWD = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire  rmq_pkg::t_ctl     i_ctl,
    input  wire  [2:0]              i_neg,
    input  wire  [NP-1:0]           i_s,
    input  wire  [2:0][NWD-1:0]     i_num,
    input  wire  [2:0][NP-1:0]      i_rem,
    input  wire  [2:0][NWD-1:0]     i_q,
    output logic                    o_valid,
    output rmq_pkg::t_ctl           o_ctl,
    output logic [2:0]              o_neg,
    output logic [NP-1:0]           o_s,
    output logic [2:0][NWD-1:0]     o_num,
    output logic [2:0][NP-1:0]      o_rem,
    output logic [2:0][NWD-1:0]     o_q
);
    logic [2:0][NP:0] r_t;
    logic [2:0]       fits;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r_t[k]  = {i_rem[k], i_num[k][NWD-1]};
            fits[k] = r_t[k] >= {1'b0, i_s};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl <= i_ctl;
            o_neg <= i_neg;
            o_s   <= i_s;
            for (int k = 0; k < 3; k++) begin
                o_num[k] <= i_num[k] << 1;
                o_rem[k] <= fits[k] ? NP'(r_t[k] - {1'b0, i_s}) : r_t[k][NP-1:0];
                o_q[k]   <= {i_q[k][NWD-2:0], fits[k]};
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Top level: rotation matrix to quaternion, Shepperd's method, fixed point.
// Depends on rmq_pkg, rmq_front, rmq_sqrt_cell and rmq_div_cell.
//
//   Channel  Direction  Handshake           Payload
//   matrix   in         i_valid / o_ready   i_mat  (rmq_pkg::t_mat_in)
//   quat     out        o_valid / i_ready   o_quat (rmq_pkg::t_quat_out)
//
// One matrix is taken every cycle while the output is not stalled; the chain is the
// entry stage, one cell per root bit, a numerator register, one cell per quotient bit and the output register.
// The whole chain advances together whenever the output register is empty or
// being taken, so a stall on the output holds every stage in place.
// Reset is synchronous and clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  rmq_pkg::t_mat_in  i_mat,
    output logic                    o_valid,
    input  wire                     i_ready,
    output rmq_pkg::t_quat_out      o_quat
);
    localparam int DW  = rmq_pkg::DATA_WIDTH;
    localparam int NB  = DW + 1;
    localparam int RW  = ((DW > FRAC_BITS + 1) ? DW : FRAC_BITS + 1) + 3;
    localparam int NP  = (RW + FRAC_BITS + 2) / 2;
    localparam int XW  = 2 * NP;
    localparam int NWD = DW + FRAC_BITS + 2;
    localparam logic [NWD-1:0] HALF = NWD'(1) << (DW - 1);

    logic adv;

    // Root chain wiring.
    logic [NP:0]                 s_valid;
    rmq_pkg::t_ctl [NP:0]        s_ctl;
    logic [NP:0][2:0][NB-1:0]    s_num;
    logic [NP:0][XW-1:0]         s_x;
    logic [NP:0][NP+1:0]         s_rem;
    logic [NP:0][NP-1:0]         s_root;

    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;

    rmq_front #(.FRAC_BITS(FRAC_BITS), .RW(RW), .XW(XW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_mat   (i_mat),
        .o_valid (s_valid[0]),
        .o_ctl   (s_ctl[0]),
        .o_x     (s_x[0]),
        .o_num   (s_num[0])
    );

    for (genvar g = 0; g < NP; g++) begin : g_sqrt
        rmq_sqrt_cell #(.NP(NP), .NB(NB)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (s_valid[g]),
            .i_ctl   (s_ctl[g]),
            .i_num   (s_num[g]),
            .i_x     (s_x[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .o_valid (s_valid[g+1]),
            .o_ctl   (s_ctl[g+1]),
            .o_num   (s_num[g+1]),
            .o_x     (s_x[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1])
        );
    end

    // Numerator preparation: magnitude scaled up, plus half of s for rounding.
    logic [2:0][NB-1:0]   mag;
    logic [2:0][NWD-1:0]  n_pnum;
    logic [2:0]           sgn;
    logic [NWD:0][2:0][NWD-1:0] d_num, d_q;
    logic [NWD:0][2:0][NP-1:0]  d_rem;
    logic [NWD:0]               d_valid;
    rmq_pkg::t_ctl [NWD:0]      d_ctl;
    logic [NWD:0][2:0]          d_neg;
    logic [NWD:0][NP-1:0]       d_s;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sgn[k]    = s_num[NP][k][NB-1];
            mag[k]    = sgn[k] ? NB'(-s_num[NP][k]) : s_num[NP][k];
            n_pnum[k] = (NWD'(mag[k]) << FRAC_BITS) + NWD'(s_root[NP] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            d_valid[0] <= 1'b0;
        end else if (adv) begin
            d_valid[0] <= s_valid[NP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            d_ctl[0] <= s_ctl[NP];
            d_neg[0] <= sgn;
            d_s[0]   <= s_root[NP];
            d_num[0] <= n_pnum;
        end
    end

    assign d_rem[0] = '0;
    assign d_q[0]   = '0;

    for (genvar g = 0; g < NWD; g++) begin : g_div
        rmq_div_cell #(.NP(NP), .NWD(NWD)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (d_valid[g]),
            .i_ctl   (d_ctl[g]),
            .i_neg   (d_neg[g]),
            .i_s     (d_s[g]),
            .i_num   (d_num[g]),
            .i_rem   (d_rem[g]),
            .i_q     (d_q[g]),
            .o_valid (d_valid[g+1]),
            .o_ctl   (d_ctl[g+1]),
            .o_neg   (d_neg[g+1]),
            .o_s     (d_s[g+1]),
            .o_num   (d_num[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_q     (d_q[g+1])
        );
    end

    // Saturation and placement of the own component.
    logic [2:0][DW-1:0] comp;
    logic [NP:0]        own_w;
    logic [DW-1:0]      own;
    rmq_pkg::t_ctl      fc;
    rmq_pkg::t_quat_out n_quat;
    rmq_pkg::t_quat_out r_quat;
    logic               r_valid;

    always_comb begin
        fc = d_ctl[NWD];
        for (int k = 0; k < 3; k++) begin
            if (d_neg[NWD][k]) begin
                comp[k] = (d_q[NWD][k] >= HALF) ? HALF[DW-1:0]
                                                : DW'(-d_q[NWD][k]);
            end else begin
                comp[k] = (d_q[NWD][k] > HALF - 1'b1) ? DW'(HALF - 1'b1)
                                                       : d_q[NWD][k][DW-1:0];
            end
        end
        own_w = ({1'b0, d_s[NWD]} + (NP+1)'(2)) >> 2;
        own   = ((NWD)'(own_w) > HALF - 1'b1) ? DW'(HALF - 1'b1) : DW'(own_w);
        n_quat.branch_taken = fc.branch;
        n_quat.degenerate   = fc.degen;
        unique case (fc.branch)
            rmq_pkg::BR_TRACE: begin
                n_quat.quat_w = own;     n_quat.quat_x = comp[0];
                n_quat.quat_y = comp[1]; n_quat.quat_z = comp[2];
            end
            rmq_pkg::BR_M00: begin
                n_quat.quat_w = comp[0]; n_quat.quat_x = own;
                n_quat.quat_y = comp[1]; n_quat.quat_z = comp[2];
            end
            rmq_pkg::BR_M11: begin
                n_quat.quat_w = comp[0]; n_quat.quat_x = comp[1];
                n_quat.quat_y = own;     n_quat.quat_z = comp[2];
            end
            default: begin
                n_quat.quat_w = comp[0]; n_quat.quat_x = comp[1];
                n_quat.quat_y = comp[2]; n_quat.quat_z = own;
            end
        endcase
        if (fc.degen) begin
            n_quat.quat_w = '0;
            n_quat.quat_x = '0;
            n_quat.quat_y = '0;
            n_quat.quat_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= d_valid[NWD];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_quat <= n_quat;
        end
    end

    assign o_valid = r_valid;
    assign o_quat  = r_quat;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_quat.degenerate |->
            o_quat.quat_w == '0 && o_quat.quat_x == '0 &&
            o_quat.quat_y == '0 && o_quat.quat_z == '0)
        else $error("degenerate result with non-zero quaternion");

    a_own_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_quat.degenerate |->
            !((o_quat.branch_taken == rmq_pkg::BR_TRACE && o_quat.quat_w[DW-1]) ||
              (o_quat.branch_taken == rmq_pkg::BR_M00 && o_quat.quat_x[DW-1]) ||
              (o_quat.branch_taken == rmq_pkg::BR_M11 && o_quat.quat_y[DW-1]) ||
              (o_quat.branch_taken == rmq_pkg::BR_M22 && o_quat.quat_z[DW-1])))
        else $error("own component of the chosen branch is negative");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !d_valid[0] && !s_valid[0])
        else $error("pipeline holds an item after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(s_valid) && $stable(d_valid))
        else $error("pipeline moved during an output stall");
endmodule
`default_nettype wire

// ===== sim/rotation_matrix_to_quaternion_tb.sv =====
// Testbench for rotation_matrix_to_quaternion: directed and random matrices are
// checked against a bit-exact predictor of the fixed-point Shepperd conversion.
// Depends on rmq_pkg and the block under rtl.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_tb;

    localparam int FRAC = 14;
    localparam int ONE = 1 << FRAC;
    localparam int N_RANDOM = 1530;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    rmq_pkg::t_mat_in i_mat = '0;
    logic o_ready, o_valid;
    rmq_pkg::t_quat_out o_quat;
    logic o_ready_at_edge = 1'b0;

    rmq_pkg::t_mat_in pending_mats[$];
    rmq_pkg::t_quat_out expected_quats[$];
    int mismatches = 0;
    int cycles = 0;
    bit stimulus_done = 1'b0;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_mat(i_mat), .o_valid(o_valid), .i_ready(i_ready), .o_quat(o_quat)
    );

    always #1 i_clk = ~i_clk;

    // floor(sqrt(r * 2^(FRAC+2)))
    function automatic longint unsigned root_scaled(longint unsigned r);
        longint unsigned v, lo, hi, mid;
        v = r << (FRAC + 2);
        lo = 0;
        hi = 64'd4294967295;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] ratio_over_s(longint num, longint unsigned s);
        longint unsigned mag, q;
        mag = (num < 0) ? -num : num;
        q = ((mag << FRAC) + (s >> 1)) / s;
        return clamp16((num < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic rmq_pkg::t_quat_out shepperd(rmq_pkg::t_mat_in m);
        rmq_pkg::t_quat_out q;
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad, n0, n1, n2;
        longint unsigned s;
        logic signed [15:0] big, c0, c1, c2;
        a00 = m.m00; a01 = m.m01; a02 = m.m02;
        a10 = m.m10; a11 = m.m11; a12 = m.m12;
        a20 = m.m20; a21 = m.m21; a22 = m.m22;
        tr = a00 + a11 + a22;
        q = '0;
        if (tr > 0) begin
            q.branch_taken = rmq_pkg::BR_TRACE; rad = tr + ONE;
            n0 = a21 - a12; n1 = a02 - a20; n2 = a10 - a01;
        end else if (a00 > a11 && a00 > a22) begin
            q.branch_taken = rmq_pkg::BR_M00; rad = ONE + a00 - a11 - a22;
            n0 = a21 - a12; n1 = a01 + a10; n2 = a02 + a20;
        end else if (a11 > a22) begin
            q.branch_taken = rmq_pkg::BR_M11; rad = ONE + a11 - a00 - a22;
            n0 = a02 - a20; n1 = a01 + a10; n2 = a12 + a21;
        end else begin
            q.branch_taken = rmq_pkg::BR_M22; rad = ONE + a22 - a00 - a11;
            n0 = a10 - a01; n1 = a02 + a20; n2 = a12 + a21;
        end
        if (rad <= 0) begin
            q.degenerate = 1'b1;
            return q;
        end
        s = root_scaled(rad);
        big = clamp16((s + 2) >> 2);
        c0 = ratio_over_s(n0, s);
        c1 = ratio_over_s(n1, s);
        c2 = ratio_over_s(n2, s);
        case (q.branch_taken)
            rmq_pkg::BR_TRACE: begin
                q.quat_w = big; q.quat_x = c0; q.quat_y = c1; q.quat_z = c2;
            end
            rmq_pkg::BR_M00: begin
                q.quat_w = c0; q.quat_x = big; q.quat_y = c1; q.quat_z = c2;
            end
            rmq_pkg::BR_M11: begin
                q.quat_w = c0; q.quat_x = c1; q.quat_y = big; q.quat_z = c2;
            end
            default: begin
                q.quat_w = c0; q.quat_x = c1; q.quat_y = c2; q.quat_z = big;
            end
        endcase
        return q;
    endfunction

    function automatic int gap_length();
        if ($urandom_range(99) < 60) return 0;
        if ($urandom_range(99) < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Mostly near-rotation values in Q1.14 so that every branch is reached.
    function automatic logic signed [15:0] entry_value();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(2 * ONE) - ONE);
            2: return 16'($urandom_range(ONE / 8) - ONE / 16);
            default: return 16'(($urandom_range(1) ? ONE : -ONE) + $urandom_range(64) - 32);
        endcase
    endfunction

    function automatic rmq_pkg::t_mat_in random_mat();
        rmq_pkg::t_mat_in m;
        m.m00 = entry_value(); m.m01 = entry_value(); m.m02 = entry_value();
        m.m10 = entry_value(); m.m11 = entry_value(); m.m12 = entry_value();
        m.m20 = entry_value(); m.m21 = entry_value(); m.m22 = entry_value();
        return m;
    endfunction

    function automatic rmq_pkg::t_mat_in diag_mat(int d0, int d1, int d2, int off);
        rmq_pkg::t_mat_in m;
        m = {9{off[15:0]}};
        m.m00 = 16'(d0); m.m11 = 16'(d1); m.m22 = 16'(d2);
        return m;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    initial begin
        rmq_pkg::t_mat_in m;
        pending_mats.push_back(diag_mat(ONE, ONE, ONE, 0));
        pending_mats.push_back(diag_mat(ONE, -ONE, -ONE, 0));
        pending_mats.push_back(diag_mat(-ONE, ONE, -ONE, 0));
        pending_mats.push_back(diag_mat(-ONE, -ONE, ONE, 0));
        pending_mats.push_back(diag_mat(0, 0, 0, 0));            // ties fall to the last branch
        pending_mats.push_back(diag_mat(-100, -100, -200, 50));  // tie on the first two
        pending_mats.push_back(diag_mat(-ONE, -ONE, -ONE, 0));   // three-way tie, radicand 2*ONE
        pending_mats.push_back(diag_mat(-32768, -32768, -32768, 0));
        pending_mats.push_back(diag_mat(32767, 32767, 32767, 32767));
        pending_mats.push_back(diag_mat(32767, 32767, 32767, -32768));
        pending_mats.push_back(diag_mat(-32768, -32768, -32768, 32767));
        pending_mats.push_back(diag_mat(1, 0, 0, -1));
        pending_mats.push_back(diag_mat(-32768, -32768, 0, 32767)); // large radicand on the last branch
        m = '1; pending_mats.push_back(m);
        m = '0; m.m01 = 32767; m.m10 = -32768; m.m21 = 32767; m.m12 = -32768;
        pending_mats.push_back(m);
        m.m00 = ONE; pending_mats.push_back(m);
        for (int i = 0; i < N_RANDOM; i++) pending_mats.push_back(random_mat());
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Driver: holds valid and payload until the transfer completes.
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready_at_edge) begin
                if (send_gap == 0 && pending_mats.size() > 0 && gap_length() == 0) begin
                    i_mat <= pending_mats.pop_front();
                end else begin
                    i_valid <= 1'b0;
                    send_gap <= gap_length();
                end
            end else if (!i_valid) begin
                if (send_gap > 0) send_gap <= send_gap - 1;
                else if (pending_mats.size() > 0) begin
                    i_mat <= pending_mats.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // Sink stall pattern.
    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(99) < 30) begin
            recv_gap <= gap_length();
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: predicts on each matrix transfer, checks each quaternion transfer.
    always @(posedge i_clk) begin
        rmq_pkg::t_quat_out want;
        cycles <= cycles + 1;
        o_ready_at_edge <= o_ready;
        if (i_rst_n && i_valid && o_ready) expected_quats.push_back(shepperd(i_mat));
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_quats.size() == 0) begin
                report("unexpected quaternion", 0, 0);
            end else begin
                want = expected_quats.pop_front();
                if (o_quat.quat_w !== want.quat_w) report("quat_w", o_quat.quat_w, want.quat_w);
                if (o_quat.quat_x !== want.quat_x) report("quat_x", o_quat.quat_x, want.quat_x);
                if (o_quat.quat_y !== want.quat_y) report("quat_y", o_quat.quat_y, want.quat_y);
                if (o_quat.quat_z !== want.quat_z) report("quat_z", o_quat.quat_z, want.quat_z);
                if (o_quat.branch_taken !== want.branch_taken)
                    report("branch_taken", o_quat.branch_taken, want.branch_taken);
                if (o_quat.degenerate !== want.degenerate)
                    report("degenerate", o_quat.degenerate, want.degenerate);
            end
        end
    end

    initial begin
        wait (stimulus_done && expected_quats.size() == 0);
        repeat (80) @(posedge i_clk);
        if (mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
    end
endmodule
